@@ design/tlo_pkg.sv @@
// Shared types, constants and helpers for the timestamped line obfuscator.
// No dependencies; every other design file except tlo_queue imports this package.
`default_nettype none

package tlo_pkg;

    localparam int BLOCK_BYTES   = 12;
    localparam int KEY_LEN       = 50;
    localparam int MAX_DIGITS    = 8;
    localparam int TLO_TOK_DEPTH = 4;
    localparam int TLO_OUT_DEPTH = 4;

    localparam logic [3:0] LAST_POS  = 4'(BLOCK_BYTES - 1);
    localparam logic [5:0] LAST_KEY  = 6'(KEY_LEN - 1);

    localparam logic [7:0] MARK_OPEN   = 8'h18;
    localparam logic [7:0] MARK_CLOSE  = 8'h19;
    localparam logic [7:0] PAD_CHAR    = 8'h31;
    localparam logic [7:0] DIGIT_BASE  = 8'h30;
    localparam logic [7:0] HIGH_BIT    = 8'h80;
    localparam logic [7:0] TRAIL_MARK  = 8'h80;
    localparam logic [7:0] NEWLINE     = 8'h0A;
    localparam logic [7:0] ENC_OFFSET  = 8'd32;

    // ceil(2^27 / 10): exact quotient by ten for any 24-bit value
    localparam logic [23:0] RECIP_TEN  = 24'd13421773;
    localparam int          RECIP_SHIFT = 27;

    localparam logic [7:0] KEY_TABLE [KEY_LEN] = '{
        8'h54, 8'h69, 8'h6D, 8'h65, 8'h73, 8'h74, 8'h61, 8'h6D, 8'h70, 8'h20,
        8'h28, 8'h46, 8'h49, 8'h43, 8'h53, 8'h29, 8'h20, 8'h76, 8'h31, 8'h2E,
        8'h30, 8'h20, 8'h2D, 8'h20, 8'h70, 8'h72, 8'h6F, 8'h67, 8'h72, 8'h61,
        8'h6D, 8'h6D, 8'h65, 8'h64, 8'h20, 8'h62, 8'h79, 8'h20, 8'h48, 8'h65,
        8'h6E, 8'h72, 8'h69, 8'h6B, 8'h20, 8'h47, 8'h72, 8'h61, 8'h6D, 8'h2E
    };

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        line_end;
        logic [23:0] timestamp_ms;
    } tlo_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       line_done;
    } tlo_out_t;

    // one byte bound for the block buffer; last marks the closing byte of a line
    typedef struct packed {
        logic       last;
        logic [7:0] value;
    } tlo_token_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_DIGIT,
        F_CLOSE
    } tlo_front_state_t;

    typedef enum logic [1:0] {
        E_BLOCK,
        E_MARK,
        E_NEWLINE
    } tlo_emit_state_t;

    // position swaps 0/11, 2/9, 4/7
    function automatic logic [3:0] blk_perm(input logic [3:0] pos);
        logic [3:0] res;
        case (pos)
            4'd0:    res = 4'd11;
            4'd11:   res = 4'd0;
            4'd2:    res = 4'd9;
            4'd9:    res = 4'd2;
            4'd4:    res = 4'd7;
            4'd7:    res = 4'd4;
            default: res = pos;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/tlo_queue.sv @@
// Small first-in first-out queue held in flip-flops.
// Depends on nothing; used between front and back and at the result side.
`default_nettype none

module tlo_queue #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/tlo_front.sv @@
// Front end: takes input beats and turns them into buffer tokens,
// writing the timestamp trailer digit by digit. Depends on tlo_pkg.
`default_nettype none

module tlo_front import tlo_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire tlo_in_t item,
    output logic         full,
    input  wire logic    tok_full,
    output logic         tok_wr,
    output tlo_token_t   tok_data
);

    tlo_front_state_t state_reg, state_next;
    logic [23:0] conv_reg, conv_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  idx_reg, idx_next;
    logic [3:0]  digits_reg [MAX_DIGITS];
    logic        digit_we;

    logic [47:0] prod;
    logic [23:0] quot;
    logic [23:0] rem;

    assign prod = {24'd0, conv_reg} * {24'd0, RECIP_TEN};
    assign quot = 24'(prod[47:RECIP_SHIFT]);
    assign rem  = conv_reg - ((quot << 3) + (quot << 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_reg <= conv_next;
        if (digit_we)
        begin
            digits_reg[cnt_reg[2:0]] <= rem[3:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        conv_next  = conv_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        digit_we   = 1'b0;
        full       = 1'b1;
        tok_wr     = 1'b0;
        tok_data   = '{last: 1'b0, value: 8'd0};
        case (state_reg)
            F_IDLE:
            begin
                full = tok_full;
                if (push && !tok_full)
                begin
                    tok_wr = 1'b1;
                    if (item.line_end)
                    begin
                        tok_data.value = MARK_OPEN;
                        conv_next      = item.timestamp_ms;
                        cnt_next       = '0;
                        state_next     = F_CONV;
                    end
                    else
                    begin
                        tok_data.value = item.data_byte;
                    end
                end
            end
            F_CONV:
            begin
                // least significant digit first
                digit_we  = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                conv_next = quot;
                if (quot == '0 || cnt_reg == 4'(MAX_DIGITS - 1))
                begin
                    idx_next   = cnt_reg[2:0];
                    state_next = F_DIGIT;
                end
            end
            F_DIGIT:
            begin
                if (!tok_full)
                begin
                    tok_wr         = 1'b1;
                    tok_data.value = DIGIT_BASE | {4'd0, digits_reg[idx_reg]};
                    if (idx_reg == '0)
                    begin
                        state_next = F_CLOSE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            F_CLOSE:
            begin
                if (!tok_full)
                begin
                    tok_wr     = 1'b1;
                    tok_data   = '{last: 1'b1, value: MARK_CLOSE};
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/tlo_back.sv @@
// Back end: packs tokens into two alternating 12-byte blocks, pads the
// last block of a line, scrambles blocks out and adds the trailer. Depends on tlo_pkg.
`default_nettype none

module tlo_back import tlo_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       tok_empty,
    input  wire tlo_token_t tok_data,
    output logic            tok_pop,
    input  wire logic       out_full,
    output logic            out_wr,
    output tlo_out_t        out_data
);

    logic [7:0] bank_reg [2][BLOCK_BYTES];
    logic [1:0] bank_full_reg;
    logic [1:0] bank_last_reg;
    logic       wr_bank_reg;
    logic [3:0] fill_reg;
    logic       rd_bank_reg;
    logic [3:0] rd_pos_reg;
    logic [5:0] key_reg;

    tlo_emit_state_t state_reg, state_next;
    logic       blk_step;
    logic       blk_end;
    logic [7:0] raw;
    logic [7:0] enc;

    assign tok_pop = !tok_empty && !bank_full_reg[wr_bank_reg];

    // closing token pads the rest of the block with '1' in the same beat
    always_ff @(posedge clk)
    begin
        if (tok_pop)
        begin
            for (int i = 0; i < BLOCK_BYTES; i++)
            begin
                if (4'(i) == fill_reg)
                begin
                    bank_reg[wr_bank_reg][i] <= tok_data.value;
                end
                else if (tok_data.last && 4'(i) > fill_reg)
                begin
                    bank_reg[wr_bank_reg][i] <= PAD_CHAR;
                end
            end
        end
    end

    assign raw     = bank_reg[rd_bank_reg][blk_perm(rd_pos_reg)];
    assign enc     = ((raw | HIGH_BIT) ^ KEY_TABLE[key_reg]) - ENC_OFFSET;
    assign blk_end = (rd_pos_reg == LAST_POS);

    always_comb
    begin
        state_next = state_reg;
        blk_step   = 1'b0;
        out_wr     = 1'b0;
        out_data   = '{out_byte: enc, line_done: 1'b0};
        case (state_reg)
            E_BLOCK:
            begin
                if (bank_full_reg[rd_bank_reg] && !out_full)
                begin
                    out_wr   = 1'b1;
                    blk_step = 1'b1;
                    if (blk_end && bank_last_reg[rd_bank_reg])
                    begin
                        state_next = E_MARK;
                    end
                end
            end
            E_MARK:
            begin
                out_data = '{out_byte: TRAIL_MARK, line_done: 1'b0};
                if (!out_full)
                begin
                    out_wr     = 1'b1;
                    state_next = E_NEWLINE;
                end
            end
            E_NEWLINE:
            begin
                out_data = '{out_byte: NEWLINE, line_done: 1'b1};
                if (!out_full)
                begin
                    out_wr     = 1'b1;
                    state_next = E_BLOCK;
                end
            end
            default:
            begin
                state_next = E_BLOCK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_BLOCK;
            bank_full_reg <= '0;
            bank_last_reg <= '0;
            wr_bank_reg   <= 1'b0;
            fill_reg      <= '0;
            rd_bank_reg   <= 1'b0;
            rd_pos_reg    <= '0;
            key_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (tok_pop)
            begin
                if (tok_data.last || fill_reg == LAST_POS)
                begin
                    bank_full_reg[wr_bank_reg] <= 1'b1;
                    bank_last_reg[wr_bank_reg] <= tok_data.last;
                    wr_bank_reg                <= ~wr_bank_reg;
                    fill_reg                   <= '0;
                end
                else
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (blk_step)
            begin
                if (blk_end && bank_last_reg[rd_bank_reg])
                begin
                    key_reg <= '0;
                end
                else
                begin
                    key_reg <= (key_reg == LAST_KEY) ? '0 : key_reg + 1'b1;
                end
                if (blk_end)
                begin
                    rd_pos_reg                 <= '0;
                    bank_full_reg[rd_bank_reg] <= 1'b0;
                    rd_bank_reg                <= ~rd_bank_reg;
                end
                else
                begin
                    rd_pos_reg <= rd_pos_reg + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/timestamped_line_obfuscator.sv @@
// Top level of the timestamped line obfuscator: front, token queue, back, result queue.
// Depends on tlo_pkg, tlo_queue, tlo_front and tlo_back.
//
//   side     beat type   handshake              accepted when
//   input    tlo_in_t    push / full            push && !full
//   result   tlo_out_t   pop / empty            pop && !empty
//
// A data byte is taken every cycle while the token queue has room; a line end holds full
// high while the decimal digits of the timestamp (1 to 8) are made one digit a cycle by the
// divide-by-ten loop in the front and then written out.
// Results leave at one byte a cycle from the block scrambler while the result queue has room; two block
// buffers let one fill while the other drains. No clearing pass after reset.
// Either side may stall; the queues in between absorb short stalls.
`default_nettype none

module timestamped_line_obfuscator import tlo_pkg::*; #(
    parameter int TOK_DEPTH = TLO_TOK_DEPTH,
    parameter int OUT_DEPTH = TLO_OUT_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire tlo_in_t item,
    output logic         empty,
    input  wire logic    pop,
    output tlo_out_t     result
);

    logic       tok_wr;
    tlo_token_t tok_wr_data;
    logic       tok_full;
    logic       tok_pop;
    tlo_token_t tok_rd_data;
    logic       tok_empty;
    logic       out_wr;
    tlo_out_t   out_wr_data;
    logic       out_full;

    tlo_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .tok_full (tok_full),
        .tok_wr   (tok_wr),
        .tok_data (tok_wr_data)
    );

    tlo_queue #(
        .WIDTH ($bits(tlo_token_t)),
        .DEPTH (TOK_DEPTH)
    ) u_tok_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_wr),
        .wr_data (tok_wr_data),
        .full    (tok_full),
        .rd_en   (tok_pop),
        .rd_data (tok_rd_data),
        .empty   (tok_empty)
    );

    tlo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_empty (tok_empty),
        .tok_data  (tok_rd_data),
        .tok_pop   (tok_pop),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_data  (out_wr_data)
    );

    tlo_queue #(
        .WIDTH ($bits(tlo_out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_wr_data),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

`default_nettype wire

@@ design/tlo_checker.sv @@
// Port-level checks for the timestamped line obfuscator, bound to the top level.
// Depends on tlo_pkg.
`default_nettype none

module tlo_checker import tlo_pkg::*; (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     push,
    input wire logic     full,
    input wire tlo_in_t  item,
    input wire logic     empty,
    input wire logic     pop,
    input wire tlo_out_t result
);

    // line end flag only ever rides on the newline
    a_done_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.line_done) |-> (result.out_byte == NEWLINE))
        else $error("line_done on a byte other than newline");

    // a waiting result beat holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result beat changed or vanished");

    // a line end keeps the input stalled while the timestamp is written out
    a_line_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && item.line_end) |=> full ##1 full)
        else $error("input taken during timestamp digits");

endmodule

bind timestamped_line_obfuscator tlo_checker u_tlo_checker (.*);

`default_nettype wire

@@ tb/tlo_line_checker.sv @@
// Line checker for the timestamped line obfuscator: follows both queue sides of the block.
// It predicts the encoded beats of every line and compares them with what leaves the block.
// Depends on tlo_pkg for the beat types only.
module tlo_line_checker import tlo_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  tlo_in_t  item,
    input  logic     pop,
    input  logic     empty,
    input  tlo_out_t result,
    output int       fail_count,
    output int       pending,
    output int       beats_checked
);

    localparam int         LINE_BLOCK = 12;
    localparam int         CIPHER_LEN = 50;
    localparam logic [7:0] STAMP_OPEN  = 8'h18;
    localparam logic [7:0] STAMP_CLOSE = 8'h19;
    localparam logic [7:0] PAD_BYTE    = 8'h31;
    localparam logic [7:0] ZERO_CHAR   = 8'h30;
    localparam logic [7:0] TOP_BIT     = 8'h80;
    localparam logic [7:0] SHIFT_DOWN  = 8'd32;
    localparam logic [7:0] TAIL_MARK   = 8'h80;
    localparam logic [7:0] LINE_FEED   = 8'h0A;

    localparam logic [7:0] CIPHER_KEY [CIPHER_LEN] = '{
        8'h54, 8'h69, 8'h6D, 8'h65, 8'h73, 8'h74, 8'h61, 8'h6D, 8'h70, 8'h20,
        8'h28, 8'h46, 8'h49, 8'h43, 8'h53, 8'h29, 8'h20, 8'h76, 8'h31, 8'h2E,
        8'h30, 8'h20, 8'h2D, 8'h20, 8'h70, 8'h72, 8'h6F, 8'h67, 8'h72, 8'h61,
        8'h6D, 8'h6D, 8'h65, 8'h64, 8'h20, 8'h62, 8'h79, 8'h20, 8'h48, 8'h65,
        8'h6E, 8'h72, 8'h69, 8'h6B, 8'h20, 8'h47, 8'h72, 8'h61, 8'h6D, 8'h2E
    };

    logic [7:0] blk_bytes [LINE_BLOCK];
    logic [3:0] blk_fill;
    logic [5:0] key_at;
    tlo_out_t   expected_beats [$];

    task automatic flag(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    task automatic scramble_block();
        logic [7:0] order [LINE_BLOCK];
        tlo_out_t   beat;
        int         i;
        for (i = 0; i < LINE_BLOCK; i++)
            order[i] = blk_bytes[i];
        order[0]  = blk_bytes[11];
        order[11] = blk_bytes[0];
        order[2]  = blk_bytes[9];
        order[9]  = blk_bytes[2];
        order[4]  = blk_bytes[7];
        order[7]  = blk_bytes[4];
        for (i = 0; i < LINE_BLOCK; i++)
        begin
            beat.out_byte  = ((order[i] | TOP_BIT) ^ CIPHER_KEY[key_at]) - SHIFT_DOWN;
            beat.line_done = 1'b0;
            expected_beats.push_back(beat);
            key_at = (key_at == 6'(CIPHER_LEN - 1)) ? 6'd0 : key_at + 6'd1;
        end
    endtask

    task automatic stash_byte(input logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 4'(LINE_BLOCK))
        begin
            scramble_block();
            blk_fill = 4'd0;
        end
    endtask

    task automatic close_line(input logic [23:0] stamp);
        logic [7:0]  digit_chars [8];
        logic [23:0] rest;
        tlo_out_t    beat;
        int          n;
        int          i;
        stash_byte(STAMP_OPEN);
        rest = stamp;
        digit_chars[0] = ZERO_CHAR + 8'(rest % 10);
        rest = rest / 10;
        n = 1;
        while (rest != 0)
        begin
            digit_chars[n] = ZERO_CHAR + 8'(rest % 10);
            rest = rest / 10;
            n++;
        end
        for (i = n - 1; i >= 0; i--)
            stash_byte(digit_chars[i]);
        stash_byte(STAMP_CLOSE);
        while (blk_fill != 4'd0)
            stash_byte(PAD_BYTE);
        beat.out_byte  = TAIL_MARK;
        beat.line_done = 1'b0;
        expected_beats.push_back(beat);
        beat.out_byte  = LINE_FEED;
        beat.line_done = 1'b1;
        expected_beats.push_back(beat);
        key_at = 6'd0;
    endtask

    initial
    begin
        fail_count    = 0;
        beats_checked = 0;
        pending       = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        tlo_out_t want;
        if (!rst_n)
        begin
            blk_fill = 4'd0;
            key_at   = 6'd0;
            expected_beats.delete();
            pending <= 0;
        end
        else
        begin
            // results leaving now were predicted at earlier edges
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                    flag($sformatf("beat %0d: %02h arrived with nothing predicted",
                                   beats_checked, result.out_byte));
                else
                begin
                    want = expected_beats.pop_front();
                    if (result.out_byte !== want.out_byte)
                        flag($sformatf("beat %0d: out_byte %02h, predicted %02h",
                                       beats_checked, result.out_byte, want.out_byte));
                    if (result.line_done !== want.line_done)
                        flag($sformatf("beat %0d: line_done %b, predicted %b",
                                       beats_checked, result.line_done, want.line_done));
                end
                beats_checked++;
            end
            if (push && !full)
            begin
                if (item.line_end)
                    close_line(item.timestamp_ms);
                else
                    stash_byte(item.data_byte);
            end
            pending <= expected_beats.size();
        end
    end

endmodule

@@ tb/timestamped_line_obfuscator_test.sv @@
// Top of the line obfuscator testbench: clock, reset, line stimulus and the verdict.
// Depends on tlo_pkg, timestamped_line_obfuscator and tlo_line_checker.
module timestamped_line_obfuscator_test;
    import tlo_pkg::*;

    localparam int TOTAL_ITEMS = 170;
    localparam int IDLE_PCT    = 38;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 64;
    localparam int CALM_FROM   = 70;
    localparam int CALM_TO     = 110;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    tlo_in_t  item;
    logic     empty;
    logic     pop;
    tlo_out_t result;

    bit       calm;
    int       fails;
    int       pending;
    int       beats_checked;
    int       items_sent;
    int       lines_sent;
    int       bytes_sent;
    int       longest;
    int       quiet;

    timestamped_line_obfuscator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    tlo_line_checker line_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .pop           (pop),
        .empty         (empty),
        .result        (result),
        .fail_count    (fails),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("no beat moved for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_beat(input logic [7:0] b, input logic last, input logic [23:0] stamp);
        tlo_in_t beat;
        beat.data_byte    = b;
        beat.line_end     = last;
        beat.timestamp_ms = stamp;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (last)
            lines_sent++;
        else
            bytes_sent++;
        calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
        @(negedge clk);
    endtask

    initial
    begin
        int          len;
        int          k;
        logic [23:0] stamp;
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        item       = '0;
        calm       = 1'b0;
        quiet      = 0;
        items_sent = 0;
        lines_sent = 0;
        bytes_sent = 0;
        longest    = 12;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // empty line, single-digit stamp
        push_beat(8'($urandom), 1'b1, 24'd0);
        // byte extremes, largest seven-digit stamp
        push_beat(8'h00, 1'b0, 24'($urandom));
        push_beat(8'hFF, 1'b0, 24'($urandom));
        push_beat(8'h80, 1'b0, 24'($urandom));
        push_beat(8'h7F, 1'b0, 24'($urandom));
        push_beat(8'($urandom), 1'b1, 24'd9999999);
        // exactly one full block, then the largest 24-bit stamp
        for (k = 0; k < 12; k++)
            push_beat(8'($urandom), 1'b0, 24'($urandom));
        push_beat(8'($urandom), 1'b1, 24'hFFFFFF);

        while (items_sent < TOTAL_ITEMS)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(75, 50) : $urandom_range(30);
            if (len > TOTAL_ITEMS - items_sent - 1)
                len = TOTAL_ITEMS - items_sent - 1;
            case ($urandom_range(3))
                0:       stamp = 24'($urandom_range(9));
                1:       stamp = 24'($urandom_range(9999999));
                2:       stamp = 24'($urandom);
                default: stamp = 24'($urandom_range(99999));
            endcase
            if (len > longest)
                longest = len;
            for (k = 0; k < len; k++)
                push_beat(8'($urandom), 1'b0, 24'($urandom));
            push_beat(8'($urandom), 1'b1, stamp);
        end
        push <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d lines with %0d data bytes, longest line %0d bytes",
                 lines_sent, bytes_sent, longest);
        $display("checked %0d encoded beats, %0d mismatches, %0d beats outstanding",
                 beats_checked, fails, pending);
        if (fails == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/tlo_pkg.sv
design/tlo_queue.sv
design/tlo_front.sv
design/tlo_back.sv
design/timestamped_line_obfuscator.sv
design/tlo_checker.sv
tb/tlo_line_checker.sv
tb/timestamped_line_obfuscator_test.sv
